@@ rtl/rrpt_pkg.sv @@
`timescale 1ns / 1ps
// rrpt_pkg: shared constants and types for the rounded rectangle pixel test
// no dependencies

package rrpt_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int QUEUE_DEPTH    = 4;
  localparam int CFG_IDX_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X        = 3'd0,
    REG_ORIGIN_Y        = 3'd1,
    REG_RECT_WIDTH      = 3'd2,
    REG_RECT_HEIGHT     = 3'd3,
    REG_RADIUS_TL       = 3'd4,
    REG_RADIUS_TR       = 3'd5,
    REG_RADIUS_BL       = 3'd6,
    REG_RADIUS_BR       = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/rrpt_front.sv @@
`timescale 1ns / 1ps
// rrpt_front: input register, corner geometry and corner classification
// depends on rrpt_pkg

module rrpt_front import rrpt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SW         = COORD_BITS + 2,
  parameter int QW         = 3 * COORD_BITS - 1 + 2 * SW
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic [COORD_BITS-1:0] origin_x,
  input  logic [COORD_BITS-1:0] origin_y,
  input  logic [COORD_BITS-1:0] rect_width,
  input  logic [COORD_BITS-1:0] rect_height,
  input  logic [COORD_BITS-2:0] radius_top_left,
  input  logic [COORD_BITS-2:0] radius_top_right,
  input  logic [COORD_BITS-2:0] radius_bottom_left,
  input  logic [COORD_BITS-2:0] radius_bottom_right,
  input  q_stat_t               q_stat,
  output logic                  push,
  output logic [QW-1:0]         push_data
);

  logic                   v1;
  logic [COORD_BITS-1:0]  px;
  logic [COORD_BITS-1:0]  py;
  logic                   accept;

  // corner centres, kept in registers
  logic signed [SW-1:0] tl_cx, tl_cy, tr_cx, tr_cy, bl_cx, bl_cy, br_cx, br_cy;

  logic signed [SW-1:0] sx0, sy0, sx1, sy1;
  logic signed [SW-1:0] s_rtl, s_rtr, s_rbl, s_rbr;
  logic signed [SW-1:0] spx, spy;
  logic signed [SW-1:0] sel_cx, sel_cy, dx, dy;
  logic [COORD_BITS-2:0] sel_r;

  assign sx0   = signed'({2'b00, origin_x});
  assign sy0   = signed'({2'b00, origin_y});
  assign sx1   = sx0 + signed'({2'b00, rect_width});
  assign sy1   = sy0 + signed'({2'b00, rect_height});
  assign s_rtl = signed'({3'b000, radius_top_left});
  assign s_rtr = signed'({3'b000, radius_top_right});
  assign s_rbl = signed'({3'b000, radius_bottom_left});
  assign s_rbr = signed'({3'b000, radius_bottom_right});

  always_ff @(posedge clk) begin
    tl_cx <= sx0 + s_rtl;
    tl_cy <= sy0 + s_rtl;
    tr_cx <= sx1 - s_rtr - SW'(1);
    tr_cy <= sy0 + s_rtr;
    bl_cx <= sx0 + s_rbl;
    bl_cy <= sy1 - s_rbl - SW'(1);
    br_cx <= sx1 - s_rbr - SW'(1);
    br_cy <= sy1 - s_rbr - SW'(1);
  end

  assign in_stall = v1 && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = v1 && !q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (accept) begin
      v1 <= 1'b1;
    end else if (push) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px <= pixel_x;
      py <= pixel_y;
    end
  end

  assign spx = signed'({2'b00, px});
  assign spy = signed'({2'b00, py});

  // first corner square holding the pixel wins
  always_comb begin
    priority if (spx < tl_cx && spy < tl_cy) begin
      sel_cx = tl_cx;
      sel_cy = tl_cy;
      sel_r  = radius_top_left;
    end else if (spx > tr_cx && spy < tr_cy) begin
      sel_cx = tr_cx;
      sel_cy = tr_cy;
      sel_r  = radius_top_right;
    end else if (spx < bl_cx && spy > bl_cy) begin
      sel_cx = bl_cx;
      sel_cy = bl_cy;
      sel_r  = radius_bottom_left;
    end else if (spx > br_cx && spy > br_cy) begin
      sel_cx = br_cx;
      sel_cy = br_cy;
      sel_r  = radius_bottom_right;
    end else begin
      // no corner: zero distance against zero radius reads as covered
      sel_cx = spx;
      sel_cy = spy;
      sel_r  = '0;
    end
  end

  assign dx        = spx - sel_cx;
  assign dy        = spy - sel_cy;
  assign push_data = {px, py, dx, dy, sel_r};

endmodule

@@ rtl/rrpt_queue.sv @@
`timescale 1ns / 1ps
// rrpt_queue: small first-word-fall-through queue between front and back
// depends on rrpt_pkg

module rrpt_queue import rrpt_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_stat_t          q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign q_stat.full  = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/rrpt_back.sv @@
`timescale 1ns / 1ps
// rrpt_back: squares the corner distances, compares against the radius, output register
// depends on rrpt_pkg

module rrpt_back import rrpt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SW         = COORD_BITS + 2,
  parameter int QW         = 3 * COORD_BITS - 1 + 2 * SW
) (
  input  logic                  clk,
  input  logic                  rst,
  input  q_stat_t               q_stat,
  input  logic [QW-1:0]         pop_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic                  inside_res
);

  localparam int RW = COORD_BITS - 1;

  logic [COORD_BITS-1:0] q_x, q_y;
  logic signed [SW-1:0]  q_dx, q_dy;
  logic [RW-1:0]         q_r;
  logic signed [2*SW-1:0] sq_dx, sq_dy;

  logic                  vm;
  logic [COORD_BITS-1:0] m_x, m_y;
  logic [2*SW-1:0]       m_dx2, m_dy2;
  logic [2*RW-1:0]       m_r2;
  logic [2*SW:0]         dist2;
  logic                  ld_o;

  assign {q_x, q_y, q_dx, q_dy, q_r} = pop_data;

  // full-width signed squares
  assign sq_dx = q_dx * q_dx;
  assign sq_dy = q_dy * q_dy;

  assign ld_o = vm && (!out_valid || !out_stall);
  assign pop  = !q_stat.empty && (!vm || ld_o);

  always_ff @(posedge clk) begin
    if (rst) begin
      vm        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        vm <= 1'b1;
      end else if (ld_o) begin
        vm <= 1'b0;
      end
      if (ld_o) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // squaring stage
  always_ff @(posedge clk) begin
    if (pop) begin
      m_x   <= q_x;
      m_y   <= q_y;
      m_dx2 <= unsigned'(sq_dx);
      m_dy2 <= unsigned'(sq_dy);
      m_r2  <= q_r * q_r;
    end
  end

  assign dist2 = {1'b0, m_dx2} + {1'b0, m_dy2};

  always_ff @(posedge clk) begin
    if (ld_o) begin
      out_x      <= m_x;
      out_y      <= m_y;
      inside_res <= (dist2 <= (2*SW+1)'(m_r2));
    end
  end

endmodule

@@ rtl/rounded_rect_pixel_test_top.sv @@
`timescale 1ns / 1ps
// rounded_rect_pixel_test_top: configuration registers, front, queue and back
// depends on rrpt_pkg, rrpt_front, rrpt_queue, rrpt_back
//
//   channel  handshake              payload
//   in       in_valid / in_stall    pixel_x, pixel_y
//   out      out_valid / out_stall  out_x, out_y, inside_res
//   cfg      cfg_wen                cfg_idx, cfg_data
//
// one pixel per cycle sustained while out_stall is low; a request passes through
// the input register, queue, squaring stage and output register, in that order
// a four-entry queue separates classification from the squaring and compare stages
// in_stall rises only once the queue and input register are full behind out_stall
// synchronous rst zeroes config and control registers; the block accepts at once

module rounded_rect_pixel_test_top import rrpt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic                  inside_res,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [COORD_BITS-1:0] cfg_data
);

  localparam int SW = COORD_BITS + 2;
  localparam int QW = 3 * COORD_BITS - 1 + 2 * SW;

  logic [COORD_BITS-1:0] origin_x, origin_y, rect_width, rect_height;
  logic [COORD_BITS-2:0] radius_top_left, radius_top_right;
  logic [COORD_BITS-2:0] radius_bottom_left, radius_bottom_right;

  q_stat_t         q_stat;
  logic            push, pop;
  logic [QW-1:0]   push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x            <= '0;
      origin_y            <= '0;
      rect_width          <= '0;
      rect_height         <= '0;
      radius_top_left     <= '0;
      radius_top_right    <= '0;
      radius_bottom_left  <= '0;
      radius_bottom_right <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        REG_ORIGIN_X:    origin_x            <= cfg_data;
        REG_ORIGIN_Y:    origin_y            <= cfg_data;
        REG_RECT_WIDTH:  rect_width          <= cfg_data;
        REG_RECT_HEIGHT: rect_height         <= cfg_data;
        REG_RADIUS_TL:   radius_top_left     <= cfg_data[COORD_BITS-2:0];
        REG_RADIUS_TR:   radius_top_right    <= cfg_data[COORD_BITS-2:0];
        REG_RADIUS_BL:   radius_bottom_left  <= cfg_data[COORD_BITS-2:0];
        REG_RADIUS_BR:   radius_bottom_right <= cfg_data[COORD_BITS-2:0];
        default:         origin_x            <= origin_x;
      endcase
    end
  end

  rrpt_front #(
    .COORD_BITS (COORD_BITS),
    .SW         (SW),
    .QW         (QW)
  ) u_front (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .pixel_x             (pixel_x),
    .pixel_y             (pixel_y),
    .origin_x            (origin_x),
    .origin_y            (origin_y),
    .rect_width          (rect_width),
    .rect_height         (rect_height),
    .radius_top_left     (radius_top_left),
    .radius_top_right    (radius_top_right),
    .radius_bottom_left  (radius_bottom_left),
    .radius_bottom_right (radius_bottom_right),
    .q_stat              (q_stat),
    .push                (push),
    .push_data           (push_data)
  );

  rrpt_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  rrpt_back #(
    .COORD_BITS (COORD_BITS),
    .SW         (SW),
    .QW         (QW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_x      (out_x),
    .out_y      (out_y),
    .inside_res (inside_res)
  );

endmodule

@@ rtl/rrpt_checker.sv @@
`timescale 1ns / 1ps
// rrpt_checker: port-level checks for the rounded rectangle pixel test, bound to the top
// depends on rrpt_pkg and rounded_rect_pixel_test_top

module rrpt_checker import rrpt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS-1:0] out_x,
  input logic [COORD_BITS-1:0] out_y,
  input logic                  inside_res
);

  // empty after reset: no result, requests taken
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("result or stall right after reset");

  // input backs up only behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_stall))
    else $error("in_stall rose without out_stall");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(out_x) && $stable(out_y) && $stable(inside_res)))
    else $error("result changed while stalled");

endmodule

bind rounded_rect_pixel_test_top rrpt_checker #(
  .COORD_BITS (COORD_BITS)
) u_rrpt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_x      (out_x),
  .out_y      (out_y),
  .inside_res (inside_res)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for rounded_rect_pixel_test_top, a queue-fed driver and a
// clocked monitor compare every result against a local coverage predictor
// depends on rrpt_pkg and the rounded_rect_pixel_test_top rtl

module tb_top;
  import rrpt_pkg::*;

  localparam int CB            = COORD_BITS_DEF;
  localparam int MAX_COORD     = (1 << CB) - 1;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 200;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
  } pixel_t;

  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          hit;
  } verdict_t;

  typedef struct {
    logic [CB-1:0] ox, oy, w, h;
    logic [CB-2:0] r_tl, r_tr, r_bl, r_br;
  } shape_t;

  typedef enum int {CORNER_TL, CORNER_TR, CORNER_BL, CORNER_BR} corner_t;

  logic          clk        = 1'b0;
  logic          rst        = 1'b1;
  logic          in_valid   = 1'b0;
  logic          in_stall;
  logic [CB-1:0] pixel_x    = '0;
  logic [CB-1:0] pixel_y    = '0;
  logic          out_valid;
  logic          out_stall  = 1'b0;
  logic [CB-1:0] out_x;
  logic [CB-1:0] out_y;
  logic          inside_res;
  logic          cfg_wen    = 1'b0;
  cfg_reg_t      cfg_idx    = REG_ORIGIN_X;
  logic [CB-1:0] cfg_data   = '0;

  shape_t   shape = '{default: '0};
  pixel_t   pixel_q[$];
  verdict_t verdict_q[$];
  pixel_t   next_px;
  verdict_t want;

  int pace_levels[3] = '{0, 3, 10};
  int gap_max        = 0;
  int stall_max      = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  int hold_left      = 0;
  int hold_asks      = 0;
  int holds_served   = 0;
  int err_cnt        = 0;
  int results_seen   = 0;
  int requests_sent  = 0;
  int settings_done  = 0;
  int cycle_cnt      = 0;

  rounded_rect_pixel_test_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_x      (out_x),
    .out_y      (out_y),
    .inside_res (inside_res),
    .cfg_wen    (cfg_wen),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic in_circle(longint dx, longint dy, longint r);
    return dx * dx + dy * dy <= r * r;
  endfunction

  function automatic logic pixel_covered(shape_t s, logic [CB-1:0] px_in,
                                         logic [CB-1:0] py_in);
    longint px, py, x0, y0, x1, y1, wd, ht, r;
    px = px_in;
    py = py_in;
    x0 = s.ox;
    y0 = s.oy;
    wd = s.w;
    ht = s.h;
    x1 = x0 + wd;
    y1 = y0 + ht;
    r = s.r_tl;
    if (px < x0 + r && py < y0 + r) return in_circle(x0 + r - px, y0 + r - py, r);
    r = s.r_tr;
    if (px >= x1 - r && py < y0 + r) return in_circle(px - (x1 - r - 1), y0 + r - py, r);
    r = s.r_bl;
    if (px < x0 + r && py >= y1 - r) return in_circle(x0 + r - px, py - (y1 - r - 1), r);
    r = s.r_br;
    if (px >= x1 - r && py >= y1 - r) begin
      return in_circle(px - (x1 - r - 1), py - (y1 - r - 1), r);
    end
    return 1'b1;
  endfunction

  function automatic logic [CB-1:0] near_coord(longint c, int spread);
    longint v;
    v = $urandom_range(0, 2 * spread);
    v = v + c - spread;
    if (v < 0) v = 0;
    if (v > MAX_COORD) v = MAX_COORD;
    return v[CB-1:0];
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        verdict_q.push_back('{x: pixel_x, y: pixel_y,
                              hit: pixel_covered(shape, pixel_x, pixel_y)});
        requests_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          next_px = pixel_q.pop_front();
          pixel_x <= next_px.x;
          pixel_y <= next_px.y;
          in_valid <= 1'b1;
          gap_left = $urandom_range(0, gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d inside=%0d", $time, out_x, out_y,
                   inside_res);
          err_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (out_x !== want.x) begin
            $display("%0t: out_x expected %0d actual %0d", $time, want.x, out_x);
            err_cnt++;
          end
          if (out_y !== want.y) begin
            $display("%0t: out_y expected %0d actual %0d", $time, want.y, out_y);
            err_cnt++;
          end
          if (inside_res !== want.hit) begin
            $display("%0t: inside_res at (%0d,%0d) expected %0d actual %0d", $time,
                     want.x, want.y, want.hit, inside_res);
            err_cnt++;
          end
        end
        results_seen++;
        stall_left = $urandom_range(0, stall_max);
      end
      if (hold_asks != holds_served) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CB-1:0] val);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      REG_ORIGIN_X:    shape.ox = val;
      REG_ORIGIN_Y:    shape.oy = val;
      REG_RECT_WIDTH:  shape.w = val;
      REG_RECT_HEIGHT: shape.h = val;
      REG_RADIUS_TL:   shape.r_tl = val[CB-2:0];
      REG_RADIUS_TR:   shape.r_tr = val[CB-2:0];
      REG_RADIUS_BL:   shape.r_bl = val[CB-2:0];
      REG_RADIUS_BR:   shape.r_br = val[CB-2:0];
      default: ;
    endcase
  endtask

  task automatic apply_shape(logic [CB-1:0] ox, logic [CB-1:0] oy, logic [CB-1:0] w,
                             logic [CB-1:0] h, logic [CB-1:0] rtl, logic [CB-1:0] rtr,
                             logic [CB-1:0] rbl, logic [CB-1:0] rbr);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_RECT_WIDTH, w);
    write_reg(REG_RECT_HEIGHT, h);
    write_reg(REG_RADIUS_TL, rtl);
    write_reg(REG_RADIUS_TR, rtr);
    write_reg(REG_RADIUS_BL, rbl);
    write_reg(REG_RADIUS_BR, rbr);
    @(posedge clk);
    cfg_wen <= 1'b0;
    settings_done++;
    @(negedge clk);
  endtask

  task automatic apply_random_shape();
    logic [CB-1:0] w, h, ox, oy;
    logic [CB-1:0] rad[4];
    int lim;
    if ($urandom_range(0, 3) == 0) begin
      w = CB'($urandom);
      h = CB'($urandom);
      ox = CB'($urandom);
      oy = CB'($urandom);
    end else begin
      w = CB'($urandom_range(0, 64));
      h = CB'($urandom_range(0, 64));
      ox = CB'($urandom_range(0, MAX_COORD - w));
      oy = CB'($urandom_range(0, MAX_COORD - h));
    end
    lim = ((w < h) ? w : h) / 2 + 2;
    foreach (rad[i]) begin
      case ($urandom_range(0, 5))
        0: rad[i] = '0;
        1: rad[i] = CB'($urandom);
        default: rad[i] = CB'($urandom_range(0, lim));
      endcase
    end
    apply_shape(ox, oy, w, h, rad[0], rad[1], rad[2], rad[3]);
  endtask

  task automatic push_pixel(logic [CB-1:0] x, logic [CB-1:0] y);
    pixel_q.push_back('{x: x, y: y});
  endtask

  // mostly pixels around the corner squares, some anywhere on screen
  task automatic push_random_pixels(int n);
    corner_t corner;
    longint cx, cy;
    int spread;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 2) begin
        push_pixel(CB'($urandom), CB'($urandom));
      end else begin
        corner = corner_t'($urandom_range(0, 3));
        case (corner)
          CORNER_TL: spread = shape.r_tl;
          CORNER_TR: spread = shape.r_tr;
          CORNER_BL: spread = shape.r_bl;
          default:   spread = shape.r_br;
        endcase
        spread = spread + 3;
        cx = shape.ox;
        cy = shape.oy;
        if (corner == CORNER_TR || corner == CORNER_BR) cx = cx + shape.w;
        if (corner == CORNER_BL || corner == CORNER_BR) cy = cy + shape.h;
        push_pixel(near_coord(cx, spread), near_coord(cy, spread));
      end
    end
  endtask

  task automatic set_pacing(int gap_cap, int stall_cap);
    gap_max = gap_cap;
    stall_max = stall_cap;
  endtask

  task automatic drain();
    do @(negedge clk); while (pixel_q.size() != 0 || in_valid || verdict_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values: only the zero-radius bottom-right square catches pixels
    set_pacing(10, 10);
    push_pixel(0, 0);
    push_pixel(CB'(MAX_COORD), CB'(MAX_COORD));
    push_pixel(1234, 2345);
    push_pixel(CB'(MAX_COORD), 0);
    drain();

    apply_shape(100, 200, 300, 150, 20, 40, 10, 0);
    set_pacing(3, 3);
    push_pixel(100, 200);
    push_pixel(101, 219);
    push_pixel(120, 200);
    push_pixel(399, 200);
    push_pixel(360, 239);
    push_pixel(100, 349);
    push_pixel(105, 345);
    push_pixel(399, 349);
    push_pixel(400, 350);
    push_pixel(250, 0);
    push_pixel(0, 0);
    push_pixel(CB'(MAX_COORD), CB'(MAX_COORD));
    push_pixel(CB'(MAX_COORD), 0);
    push_pixel(0, CB'(MAX_COORD));
    drain();

    // corner squares overlap, earlier corner wins
    apply_shape(50, 60, 10, 8, 6, 5, 7, 3);
    push_pixel(52, 62);
    push_pixel(56, 65);
    push_pixel(58, 63);
    push_pixel(59, 67);
    push_pixel(50, 67);
    push_pixel(55, 61);
    drain();

    apply_shape('1, '1, '1, '1, '1, '1, '1, '1);
    set_pacing(pace_levels[$urandom_range(0, 2)], pace_levels[$urandom_range(0, 2)]);
    push_random_pixels(60);
    drain();

    apply_shape('0, '0, '0, '0, '0, '0, '0, '0);
    push_random_pixels(40);
    drain();

    apply_shape(0, 0, CB'(MAX_COORD), CB'(MAX_COORD), CB'(MAX_COORD >> 1),
                CB'(MAX_COORD >> 1), CB'(MAX_COORD >> 1), CB'(MAX_COORD >> 1));
    push_random_pixels(80);
    drain();

    for (int p = 0; p < 10; p++) begin
      apply_random_shape();
      if (p == 0) begin
        set_pacing(0, 0);
      end else if (p == 1) begin
        set_pacing(0, 2);
        hold_asks <= hold_asks + 1;
      end else begin
        set_pacing(pace_levels[$urandom_range(0, 2)], pace_levels[$urandom_range(0, 2)]);
      end
      push_random_pixels(125);
      drain();
    end

    if (verdict_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, verdict_q.size());
      err_cnt++;
    end
    $display("%0d pixel requests sent, %0d results checked over %0d rectangle settings",
             requests_sent, results_seen, settings_done);
    $display("%0d mismatches, including one long output hold-off", err_cnt);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rrpt_pkg.sv
rtl/rrpt_front.sv
rtl/rrpt_queue.sv
rtl/rrpt_back.sv
rtl/rounded_rect_pixel_test_top.sv
rtl/rrpt_checker.sv
sim/tb_top.sv
